[src/packet_crc16_kermit_check_assert.svh]
// assertion macros shared by the checker block
`ifndef PACKET_CRC16_KERMIT_CHECK_ASSERT_SVH
`define PACKET_CRC16_KERMIT_CHECK_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CRC16K_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc16k check failed");

// next-cycle implication, disabled while in reset
`define CRC16K_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc16k check failed");

`endif

[src/crc16k_pkg.sv]
package crc16k_pkg;

	// one incoming byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_item_t;

	// result codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_TYPE = 2'd2
	} status_t;

	// one result
	typedef struct packed {
		status_t     status;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
		logic [11:0] length_field;
	} res_item_t;

	// packet parse phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BODY  = 2'd1,
		PH_CRCLO = 2'd2,
		PH_CRCHI = 2'd3
	} phase_t;

	localparam logic [15:0] HI_NIB_TAB [16] = '{
		16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
		16'h8408, 16'h9489, 16'hA50A, 16'hB58B, 16'hC60C, 16'hD68D, 16'hE70E, 16'hF78F
	};

	localparam logic [15:0] LO_NIB_TAB [16] = '{
		16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
		16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
	};

	// reflected crc-16 (poly 0x8408) update by one byte, two nibble tables
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc[7:0] ^ b;
		return {8'h00, crc[15:8]} ^ HI_NIB_TAB[c[7:4]] ^ LO_NIB_TAB[c[3:0]];
	endfunction

endpackage

[src/crc16k_chan_if.sv]
interface crc16k_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/packet_crc16_kermit_check.sv]
// Byte-stream mini-packet checker with a reflected CRC-16 (poly 0x8408, init 0).
// pkt_in: one transaction per packet byte; packet_start flags byte 0, whose high
//   nibble is the type and low nibble length bits 11..8; byte 1 is length 7..0.
// res_out: one transaction per packet: ok or bad CRC after the second CRC byte,
//   or wrong type right after a header whose type differs from expected_type.
// cfg: 4-bit expected_type write, always ready; write it only while idle.
// Throughput: one byte per cycle while no res_out stall holds the result register;
//   the CRC byte update is combinational between the input and result registers.
// Path: an accepted byte goes through the input register, then its result through the result register to res_out.
// Receiver stall: the result register holds; at most one more byte is taken
//   into the input register, after which pkt_in.ready drops until res_out drains.
// Reset: clears the parse state to idle, expected_type to 0 and both valids.
`include "packet_crc16_kermit_check_assert.svh"

module packet_crc16_kermit_check (
	input  logic          clk,
	input  logic          arst_n,
	crc16k_chan_if.sink   pkt_in,
	crc16k_chan_if.sink   cfg,
	crc16k_chan_if.source res_out
);

	logic                 valid_s1;
	logic                 advance;
	crc16k_pkg::in_item_t item_s1;

	// input register
	crc16k_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_in   (pkt_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// parser, crc and result register
	crc16k_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.res_out  (res_out)
	);

	// wrong type carries all-zero fields
	`CRC16K_ASSERT_IMP(a_type_zero, clk, arst_n,
		res_out.valid && res_out.data.status == crc16k_pkg::ST_TYPE,
		res_out.data.computed_crc == 16'h0 && res_out.data.received_crc == 16'h0
			&& res_out.data.length_field == 12'h0)
	// ok means the two crcs agree
	`CRC16K_ASSERT_IMP(a_ok_match, clk, arst_n,
		res_out.valid && res_out.data.status == crc16k_pkg::ST_OK,
		res_out.data.computed_crc == res_out.data.received_crc)
	// bad means they differ
	`CRC16K_ASSERT_IMP(a_bad_diff, clk, arst_n,
		res_out.valid && res_out.data.status == crc16k_pkg::ST_BAD,
		res_out.data.computed_crc != res_out.data.received_crc)
	// a byte held in the input register with a free result slot drains next cycle
	`CRC16K_ASSERT_NXT(a_drain, clk, arst_n,
		valid_s1 && !res_out.valid && !pkt_in.valid,
		!valid_s1)

endmodule

[src/crc16k_in_reg.sv]
module crc16k_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	crc16k_chan_if.sink          pkt_in,
	input  logic                 advance,
	output logic                 valid_s1,
	output crc16k_pkg::in_item_t item_s1
);

	logic                 vld_s1;
	crc16k_pkg::in_item_t itm_s1;

	// take a new transaction whenever the stage is empty or drains this cycle
	assign pkt_in.ready = !vld_s1 || advance;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pkt_in.ready) begin
			vld_s1 <= pkt_in.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pkt_in.ready && pkt_in.valid) begin
			itm_s1 <= pkt_in.data;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;

endmodule

[src/crc16k_core.sv]
module crc16k_core (
	input  logic                 clk,
	input  logic                 arst_n,
	crc16k_chan_if.sink          cfg,
	input  logic                 valid_s1,
	input  crc16k_pkg::in_item_t item_s1,
	output logic                 advance,
	crc16k_chan_if.source        res_out
);

	logic [3:0]            exp_type_q;
	crc16k_pkg::phase_t    phase_q, phase_n;
	logic [15:0]           crc_q, crc_n;
	logic [12:0]           pos_q, pos_n;
	logic [11:0]           len_q, len_n;
	logic [7:0]            crc_lo_q, crc_lo_n;
	logic                  out_valid_q;
	crc16k_pkg::res_item_t out_item_q;

	logic                  type_ok;
	logic                  at_len_byte;
	logic [11:0]           len_v;
	logic                  res_fire;
	crc16k_pkg::res_item_t res;
	logic [15:0]           recv;
	logic [7:0]            b;

	// config register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_type_q <= '0;
		end else if (cfg.valid) begin
			exp_type_q <= cfg.data;
		end
	end

	// stage moves when the result register is free or being emptied
	assign advance = valid_s1 && (!out_valid_q || res_out.ready);

	// shared decode
	assign b           = item_s1.data_byte;
	assign type_ok     = (b[7:4] == exp_type_q);
	assign at_len_byte = (pos_q == 13'd1);
	assign len_v       = at_len_byte ? {len_q[11:8], b} : len_q;
	assign recv        = {b, crc_lo_q};

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (item_s1.packet_start) begin
			phase_n = type_ok ? crc16k_pkg::PH_BODY : crc16k_pkg::PH_IDLE;
		end else begin
			unique case (phase_q)
				crc16k_pkg::PH_BODY: begin
					if (at_len_byte && len_v == 12'd0) begin
						phase_n = crc16k_pkg::PH_CRCHI;
					end else if (pos_q >= {1'b0, len_v}) begin
						phase_n = crc16k_pkg::PH_CRCLO;
					end
				end
				crc16k_pkg::PH_CRCLO: phase_n = crc16k_pkg::PH_CRCHI;
				crc16k_pkg::PH_CRCHI: phase_n = crc16k_pkg::PH_IDLE;
				default:              phase_n = crc16k_pkg::PH_IDLE;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		crc_n    = crc_q;
		pos_n    = pos_q;
		len_n    = len_q;
		crc_lo_n = crc_lo_q;
		res_fire = 1'b0;
		res      = '0;
		if (item_s1.packet_start) begin
			crc_n    = '0;
			pos_n    = '0;
			len_n    = '0;
			crc_lo_n = '0;
			if (!type_ok) begin
				res_fire   = 1'b1;
				res.status = crc16k_pkg::ST_TYPE;
			end else begin
				crc_n = crc16k_pkg::crc_byte(16'h0000, b);
				len_n = {b[3:0], 8'h00};
				pos_n = 13'd1;
			end
		end else begin
			unique case (phase_q)
				crc16k_pkg::PH_BODY: begin
					len_n = len_v;
					if (at_len_byte && len_v == 12'd0) begin
						// zero length: this byte doubles as the crc low byte
						crc_lo_n = b;
					end else begin
						crc_n = crc16k_pkg::crc_byte(crc_q, b);
						if (pos_q < {1'b0, len_v}) begin
							pos_n = pos_q + 13'd1;
						end
					end
				end
				crc16k_pkg::PH_CRCLO: crc_lo_n = b;
				crc16k_pkg::PH_CRCHI: begin
					res_fire         = 1'b1;
					res.status       = (crc_q == recv) ? crc16k_pkg::ST_OK
					                                   : crc16k_pkg::ST_BAD;
					res.computed_crc = crc_q;
					res.received_crc = recv;
					res.length_field = len_q;
				end
				default: ;
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= crc16k_pkg::PH_IDLE;
			crc_q    <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			crc_lo_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			crc_q    <= crc_n;
			pos_q    <= pos_n;
			len_q    <= len_n;
			crc_lo_q <= crc_lo_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			out_item_q <= res;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_item_q;

endmodule

[test/packet_crc16_kermit_check_tb.sv]
`timescale 1ns / 100ps

module packet_crc16_kermit_check_tb;

	localparam int CYCLE_LIMIT = 800000;

	logic clk = 1'b0;
	logic arst_n;

	crc16k_chan_if #(.T(crc16k_pkg::in_item_t))  pkt_if ();
	crc16k_chan_if #(.T(logic [3:0]))            cfg_if ();
	crc16k_chan_if #(.T(crc16k_pkg::res_item_t)) res_if ();

	packet_crc16_kermit_check u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt_in (pkt_if),
		.cfg    (cfg_if),
		.res_out(res_if)
	);

	// bytes waiting to be sent, and results the checker still owes
	crc16k_pkg::in_item_t  byte_q[$];
	crc16k_pkg::res_item_t crc_result_q[$];

	int fail_cnt = 0;
	int cycle_cnt = 0;
	int bytes_queued = 0;
	logic [3:0] gen_type = 4'h0;

	// shadow of the parser state
	logic [3:0]  type_cfg = 4'h0;
	logic [15:0] crc_run = 16'h0;
	logic [12:0] pos_cnt = 13'h0;
	logic [11:0] len_hdr = 12'h0;
	logic [7:0]  crc_lo_held = 8'h0;
	crc16k_pkg::phase_t parse_phase = crc16k_pkg::PH_IDLE;

	// pacing of both sides
	int send_wait;
	int hold_cnt;
	bit sender_calm = 1'b0;
	bit sink_calm = 1'b0;

	always #4 clk = ~clk;

	// reflected crc-16, poly 0x8408, one bit at a time
	function automatic logic [15:0] kermit_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
		return c;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 2);
		else if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// packet length, mostly small
	function automatic logic [11:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 12'd0;
		else if (r < 20)
			return 12'd1;
		else if (r < 85)
			return 12'($urandom_range(2, 16));
		else if (r < 98)
			return 12'($urandom_range(17, 64));
		return 12'($urandom_range(200, 600));
	endfunction

	// advance the shadow parser by one accepted byte
	task automatic parse_byte(input crc16k_pkg::in_item_t it);
		crc16k_pkg::res_item_t r;
		logic [15:0] rx;
		if (it.packet_start) begin
			crc_run = 16'h0;
			pos_cnt = 13'h0;
			len_hdr = 12'h0;
			crc_lo_held = 8'h0;
			if (it.data_byte[7:4] != type_cfg) begin
				parse_phase = crc16k_pkg::PH_IDLE;
				r.status = crc16k_pkg::ST_TYPE;
				r.computed_crc = 16'h0;
				r.received_crc = 16'h0;
				r.length_field = 12'h0;
				crc_result_q.push_back(r);
			end else begin
				crc_run = kermit_next(16'h0, it.data_byte);
				len_hdr = {it.data_byte[3:0], 8'h00};
				pos_cnt = 13'd1;
				parse_phase = crc16k_pkg::PH_BODY;
			end
		end else begin
			case (parse_phase)
				crc16k_pkg::PH_BODY: begin
					if (pos_cnt == 13'd1)
						len_hdr[7:0] = it.data_byte;
					if (pos_cnt == 13'd1 && len_hdr == 12'h0) begin
						// zero length: this byte doubles as the crc low byte
						crc_lo_held = it.data_byte;
						parse_phase = crc16k_pkg::PH_CRCHI;
					end else begin
						crc_run = kermit_next(crc_run, it.data_byte);
						if (pos_cnt >= {1'b0, len_hdr})
							parse_phase = crc16k_pkg::PH_CRCLO;
						else
							pos_cnt = pos_cnt + 13'd1;
					end
				end
				crc16k_pkg::PH_CRCLO: begin
					crc_lo_held = it.data_byte;
					parse_phase = crc16k_pkg::PH_CRCHI;
				end
				crc16k_pkg::PH_CRCHI: begin
					rx = {it.data_byte, crc_lo_held};
					parse_phase = crc16k_pkg::PH_IDLE;
					r.status = (crc_run == rx) ? crc16k_pkg::ST_OK : crc16k_pkg::ST_BAD;
					r.computed_crc = crc_run;
					r.received_crc = rx;
					r.length_field = len_hdr;
					crc_result_q.push_back(r);
				end
				default: ;
			endcase
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic s);
		crc16k_pkg::in_item_t it;
		it.data_byte = b;
		it.packet_start = s;
		byte_q.push_back(it);
		bytes_queued++;
	endtask

	// bytes the block ignores or drops, not counted as stimulus
	task automatic add_noise(input int n);
		crc16k_pkg::in_item_t it;
		repeat (n) begin
			it.data_byte = 8'($urandom);
			it.packet_start = 1'b0;
			byte_q.push_back(it);
		end
	endtask

	// build one packet; keep only the first cut bytes when cut > 0
	task automatic add_packet(input logic [3:0] ty, input logic [11:0] len, input bit corrupt,
			input int cut);
		logic [7:0]  pk[$];
		logic [15:0] crc;
		logic [7:0]  d;
		int n;
		pk.push_back({ty, len[11:8]});
		crc = kermit_next(16'h0, pk[0]);
		if (len == 12'h0) begin
			pk.push_back(8'h00);
			d = crc[15:8];
			if (corrupt)
				d = d ^ (8'h01 << $urandom_range(0, 7));
			pk.push_back(d);
		end else begin
			pk.push_back(len[7:0]);
			crc = kermit_next(crc, len[7:0]);
			for (int i = 2; i <= len; i++) begin
				d = 8'($urandom);
				pk.push_back(d);
				crc = kermit_next(crc, d);
			end
			if (corrupt)
				crc = crc ^ (16'h0001 << $urandom_range(0, 15));
			pk.push_back(crc[7:0]);
			pk.push_back(crc[15:8]);
		end
		n = (cut > 0 && cut < pk.size()) ? cut : pk.size();
		for (int i = 0; i < n; i++)
			add_byte(pk[i], i == 0);
	endtask

	// random mix of packets, wrong types, cut packets and noise
	task automatic rand_phase(input int n);
		int target;
		int r;
		target = bytes_queued + n;
		while (bytes_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				add_packet(gen_type, pick_len(), $urandom_range(0, 3) == 0, 0);
			end else if (r < 72) begin
				add_byte({gen_type ^ 4'($urandom_range(1, 15)), 4'($urandom)}, 1'b1);
				add_noise($urandom_range(0, 3));
			end else if (r < 86) begin
				add_packet(gen_type, 12'($urandom), 1'b0, $urandom_range(1, 12));
			end else begin
				add_noise($urandom_range(1, 3));
			end
		end
		// leave the parser idle
		add_packet(gen_type, 12'($urandom_range(1, 8)), 1'b0, 0);
	endtask

	task automatic write_type(input logic [3:0] v);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		gen_type = v;
		@(negedge clk);
	endtask

	// wait until all bytes went out and all results came back
	task automatic wait_drain();
		do
			@(negedge clk);
		while (byte_q.size() != 0 || pkt_if.valid || crc_result_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_if.valid <= 1'b0;
			pkt_if.data <= '0;
			send_wait <= 0;
		end else if (!pkt_if.valid || pkt_if.ready) begin
			if (send_wait > 0) begin
				pkt_if.valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (byte_q.size() > 0) begin
				pkt_if.valid <= 1'b1;
				pkt_if.data <= byte_q.pop_front();
				send_wait <= sender_calm ? 0 : idle_len();
				if ($urandom_range(0, 49) == 0)
					sender_calm <= !sender_calm;
			end else begin
				pkt_if.valid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (hold_cnt > 0) begin
				res_if.ready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if (!sink_calm && $urandom_range(0, 6) == 0) begin
				res_if.ready <= 1'b0;
				hold_cnt <= idle_len();
			end else begin
				res_if.ready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0)
				sink_calm <= !sink_calm;
		end
	end

	// monitor: check results, then track config and bytes
	always @(posedge clk) begin : mon
		crc16k_pkg::res_item_t got;
		crc16k_pkg::res_item_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (crc_result_q.size() == 0) begin
					$error("unexpected result transaction: status %0d", got.status);
					fail_cnt++;
				end else begin
					want = crc_result_q.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_cnt++;
					end
					if (got.computed_crc !== want.computed_crc) begin
						$error("computed_crc: expected %h, got %h",
							want.computed_crc, got.computed_crc);
						fail_cnt++;
					end
					if (got.received_crc !== want.received_crc) begin
						$error("received_crc: expected %h, got %h",
							want.received_crc, got.received_crc);
						fail_cnt++;
					end
					if (got.length_field !== want.length_field) begin
						$error("length_field: expected %0d, got %0d",
							want.length_field, got.length_field);
						fail_cnt++;
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready)
				type_cfg = cfg_if.data;
			if (pkt_if.valid && pkt_if.ready)
				parse_byte(pkt_if.data);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = 4'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero and one length, bad crc, wrong type, restart mid-packet
		write_type(4'hF);
		add_packet(4'hF, 12'd0, 1'b0, 0);
		add_packet(4'hF, 12'd1, 1'b0, 0);
		add_packet(4'hF, 12'd2, 1'b1, 0);
		add_byte(8'h0F, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_packet(4'hF, 12'hFFF, 1'b0, 3);
		add_packet(4'hF, 12'd2, 1'b0, 0);
		add_byte(8'hE5, 1'b1);
		wait_drain();

		write_type(4'h0);
		rand_phase(160);
		wait_drain();

		write_type(4'($urandom_range(1, 14)));
		rand_phase(160);
		wait_drain();

		// one long packet, then random traffic
		write_type(4'hF);
		add_packet(4'hF, 12'h2FF, 1'b0, 0);
		rand_phase(160);
		wait_drain();

		write_type(4'($urandom));
		rand_phase(160);
		wait_drain();

		repeat (10) @(negedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
